// ----- sv/ura_pkg.sv -----
// Shared types and constants for the ultrasonic range-to-ASCII block.
package ura_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TRIGGER = 4'b0010,
        PH_WAIT    = 4'b0100,
        PH_COUNT   = 4'b1000
    } phase_t;

    typedef logic [1:0] status_t;
    localparam status_t ST_NONE  = 2'd0;
    localparam status_t ST_CHAR  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    // Position inside a reading; single results sit at the final position.
    typedef logic [2:0] seq_t;
    localparam seq_t SEQ_HUND = 3'd0;
    localparam seq_t SEQ_TENS = 3'd1;
    localparam seq_t SEQ_ONES = 3'd2;
    localparam seq_t SEQ_C    = 3'd3;
    localparam seq_t SEQ_M    = 3'd4;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_TRIGGER_TICKS = 2'd0;
    localparam reg_index_t REG_MIN_CM        = 2'd1;
    localparam reg_index_t REG_MAX_CM        = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_C    = 8'h63;
    localparam logic [7:0] ASCII_M    = 8'h6d;

    localparam logic [15:0] TRIGGER_TICKS_RESET = 16'd12500;
    localparam logic [9:0]  MIN_CM_RESET        = 10'd2;
    localparam logic [9:0]  MAX_CM_RESET        = 10'd400;

endpackage

// ----- sv/ultrasonic_range_to_ascii.sv -----
// Ultrasonic rangefinder controller: trigger pulse, echo timing, ASCII distance readout.
// Each input item is one timer tick (cmd 0) or a start command (cmd 1). Starts and most
// ticks give one result each, so the block sustains one item per cycle while the output
// side keeps taking results. The tick on which the echo falls ends the measurement and
// gives five results ('hundreds', 'tens', 'ones', 'c', 'm') in range or one out-of-range
// status result; the next item is taken in the cycle the final result of that group
// transfers. The distance floor(count*10/DIVISOR_TENTHS)+1 is kept up to date on every
// echo tick as a running quotient and remainder plus decimal digits, so no divider sits
// in the path. Configuration writes take effect at once and are meant to be issued while
// the block is idle.
module ultrasonic_range_to_ascii #(
    parameter int DIVISOR_TENTHS = 588,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        echo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        trigger,
    output logic [7:0]  char_code,
    output logic [1:0]  status,
    output logic        last
);

    localparam int REM_W = (DIVISOR_TENTHS > 1) ? $clog2(2 * DIVISOR_TENTHS) : 1;
    localparam logic [3:0]       Q10  = 4'(10 / DIVISOR_TENTHS);
    localparam logic [REM_W-1:0] R10  = REM_W'(10 % DIVISOR_TENTHS);
    localparam logic [REM_W-1:0] DIVC = REM_W'(DIVISOR_TENTHS);

    // configuration
    logic [15:0] trigger_ticks_reg;
    logic [9:0]  min_cm_reg;
    logic [9:0]  max_cm_reg;

    // measurement state
    ura_pkg::phase_t        phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [15:0]            trigger_left_reg, trigger_left_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [10:0]            dist_reg, dist_next;   // saturates, only compared to 10-bit bounds
    logic [3:0]             ones_reg, ones_next;
    logic [3:0]             tens_reg, tens_next;
    logic [7:0]             hund_reg, hund_next;   // only needed modulo 256

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              trig_out_reg, trig_out_next;
    ura_pkg::status_t  status_reg, status_next;
    ura_pkg::seq_t     seq_reg, seq_next;
    logic [7:0]        hund_ch_reg, hund_ch_next;
    logic [7:0]        tens_ch_reg, tens_ch_next;
    logic [7:0]        ones_ch_reg, ones_ch_next;

    logic in_fire;
    logic out_fire;

    // one echo tick step of the running distance
    logic [REM_W-1:0] base_rem, rem_sum, rem_step;
    logic [10:0]      base_dist, dist_step;
    logic [11:0]      dist_sum;
    logic [3:0]       base_ones, base_tens, ones_step, tens_step;
    logic [7:0]       base_hund, hund_step;
    logic [3:0]       inc;
    logic [4:0]       s1;
    logic [3:0]       s2;
    logic [1:0]       c1;
    logic             c2;
    logic             rem_carry;
    logic             in_range;

    assign out_fire = out_valid_reg && out_ready;
    assign in_ready = !out_valid_reg || (out_fire && seq_reg == ura_pkg::SEQ_M);
    assign in_fire  = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign trigger   = trig_out_reg;
    assign status    = status_reg;
    assign last      = (seq_reg == ura_pkg::SEQ_M);

    always_comb
    begin
        if (status_reg != ura_pkg::ST_CHAR)
        begin
            char_code = 8'h00;
        end
        else
        begin
            case (seq_reg)
                ura_pkg::SEQ_HUND: char_code = hund_ch_reg;
                ura_pkg::SEQ_TENS: char_code = tens_ch_reg;
                ura_pkg::SEQ_ONES: char_code = ones_ch_reg;
                ura_pkg::SEQ_C:    char_code = ura_pkg::ASCII_C;
                default:           char_code = ura_pkg::ASCII_M;
            endcase
        end
    end

    // Step from the current value while counting, from the zero-count value on echo rise.
    always_comb
    begin
        if (phase_reg == ura_pkg::PH_COUNT)
        begin
            base_rem  = rem_reg;
            base_dist = dist_reg;
            base_ones = ones_reg;
            base_tens = tens_reg;
            base_hund = hund_reg;
        end
        else
        begin
            base_rem  = '0;
            base_dist = 11'd1;
            base_ones = 4'd1;
            base_tens = 4'd0;
            base_hund = 8'd0;
        end

        rem_sum   = base_rem + R10;
        rem_carry = (rem_sum >= DIVC);
        rem_step  = rem_carry ? (rem_sum - DIVC) : rem_sum;
        inc       = Q10 + 4'(rem_carry);

        dist_sum  = {1'b0, base_dist} + {8'd0, inc};
        dist_step = dist_sum[11] ? 11'h7ff : dist_sum[10:0];

        s1 = {1'b0, base_ones} + {1'b0, inc};
        if (s1 >= 5'd20)
        begin
            ones_step = 4'(s1 - 5'd20);
            c1        = 2'd2;
        end
        else if (s1 >= 5'd10)
        begin
            ones_step = 4'(s1 - 5'd10);
            c1        = 2'd1;
        end
        else
        begin
            ones_step = s1[3:0];
            c1        = 2'd0;
        end

        s2 = base_tens + {2'b00, c1};
        if (s2 >= 4'd10)
        begin
            tens_step = s2 - 4'd10;
            c2        = 1'b1;
        end
        else
        begin
            tens_step = s2;
            c2        = 1'b0;
        end
        hund_step = base_hund + {7'd0, c2};
    end

    assign in_range = (dist_reg >= {1'b0, min_cm_reg}) && (dist_reg <= {1'b0, max_cm_reg});

    always_comb
    begin
        phase_next        = phase_reg;
        count_next        = count_reg;
        trigger_left_next = trigger_left_reg;
        rem_next          = rem_reg;
        dist_next         = dist_reg;
        ones_next         = ones_reg;
        tens_next         = tens_reg;
        hund_next         = hund_reg;

        out_valid_next = out_valid_reg;
        trig_out_next  = trig_out_reg;
        status_next    = status_reg;
        seq_next       = seq_reg;
        hund_ch_next   = hund_ch_reg;
        tens_ch_next   = tens_ch_reg;
        ones_ch_next   = ones_ch_reg;

        if (out_fire)
        begin
            if (seq_reg == ura_pkg::SEQ_M)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                seq_next = seq_reg + 3'd1;
            end
        end

        if (in_fire)
        begin
            out_valid_next = 1'b1;
            trig_out_next  = 1'b0;
            status_next    = ura_pkg::ST_NONE;
            seq_next       = ura_pkg::SEQ_M;

            if (cmd)
            begin
                phase_next        = ura_pkg::PH_TRIGGER;
                count_next        = '0;
                trigger_left_next = (trigger_ticks_reg == 16'd0) ? 16'd1 : trigger_ticks_reg;
                rem_next          = '0;
                dist_next         = 11'd1;
                ones_next         = 4'd1;
                tens_next         = 4'd0;
                hund_next         = 8'd0;
                trig_out_next     = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    ura_pkg::PH_TRIGGER:
                    begin
                        trigger_left_next = trigger_left_reg - 16'd1;
                        if (trigger_left_reg == 16'd1)
                        begin
                            phase_next = ura_pkg::PH_WAIT;
                        end
                        else
                        begin
                            trig_out_next = 1'b1;
                        end
                    end
                    ura_pkg::PH_WAIT:
                    begin
                        if (echo)
                        begin
                            phase_next = ura_pkg::PH_COUNT;
                            count_next = COUNT_WIDTH'(1);
                            rem_next   = rem_step;
                            dist_next  = dist_step;
                            ones_next  = ones_step;
                            tens_next  = tens_step;
                            hund_next  = hund_step;
                        end
                    end
                    ura_pkg::PH_COUNT:
                    begin
                        if (echo)
                        begin
                            count_next = count_reg + COUNT_WIDTH'(1);
                            if (count_reg == {COUNT_WIDTH{1'b1}})
                            begin
                                // counter wraps back to zero ticks
                                rem_next  = '0;
                                dist_next = 11'd1;
                                ones_next = 4'd1;
                                tens_next = 4'd0;
                                hund_next = 8'd0;
                            end
                            else
                            begin
                                rem_next  = rem_step;
                                dist_next = dist_step;
                                ones_next = ones_step;
                                tens_next = tens_step;
                                hund_next = hund_step;
                            end
                        end
                        else
                        begin
                            phase_next   = ura_pkg::PH_IDLE;
                            hund_ch_next = hund_reg + ura_pkg::ASCII_ZERO;
                            tens_ch_next = {4'd0, tens_reg} + ura_pkg::ASCII_ZERO;
                            ones_ch_next = {4'd0, ones_reg} + ura_pkg::ASCII_ZERO;
                            if (in_range)
                            begin
                                status_next = ura_pkg::ST_CHAR;
                                seq_next    = ura_pkg::SEQ_HUND;
                            end
                            else
                            begin
                                status_next = ura_pkg::ST_RANGE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= ura_pkg::TRIGGER_TICKS_RESET;
            min_cm_reg        <= ura_pkg::MIN_CM_RESET;
            max_cm_reg        <= ura_pkg::MAX_CM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ura_pkg::REG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data;
                ura_pkg::REG_MIN_CM:        min_cm_reg        <= cfg_data[9:0];
                ura_pkg::REG_MAX_CM:        max_cm_reg        <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ura_pkg::PH_IDLE;
            count_reg        <= '0;
            trigger_left_reg <= '0;
            rem_reg          <= '0;
            dist_reg         <= 11'd1;
            ones_reg         <= 4'd1;
            tens_reg         <= 4'd0;
            hund_reg         <= 8'd0;
            out_valid_reg    <= 1'b0;
            seq_reg          <= ura_pkg::SEQ_M;
            status_reg       <= ura_pkg::ST_NONE;
        end
        else
        begin
            phase_reg        <= phase_next;
            count_reg        <= count_next;
            trigger_left_reg <= trigger_left_next;
            rem_reg          <= rem_next;
            dist_reg         <= dist_next;
            ones_reg         <= ones_next;
            tens_reg         <= tens_next;
            hund_reg         <= hund_next;
            out_valid_reg    <= out_valid_next;
            seq_reg          <= seq_next;
            status_reg       <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trig_out_reg <= trig_out_next;
        hund_ch_reg  <= hund_ch_next;
        tens_ch_reg  <= tens_ch_next;
        ones_ch_reg  <= ones_ch_next;
    end

    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && cmd) |=> (out_valid && trigger && status == ura_pkg::ST_NONE && last))
        else $error("start transfer did not give a trigger-high result");

    a_reading_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && status == ura_pkg::ST_CHAR && !last) |=>
        (out_valid && status == ura_pkg::ST_CHAR && (last || !in_ready)))
        else $error("reading sequence broken");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cmd && !echo && phase_reg == ura_pkg::PH_COUNT) |=>
        (phase_reg == ura_pkg::PH_IDLE && status != ura_pkg::ST_NONE))
        else $error("echo fall did not end the measurement");

    a_trigger_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ura_pkg::PH_TRIGGER) |-> (trigger_left_reg != 16'd0))
        else $error("trigger phase with no ticks left");

    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (ones_reg <= 4'd9) && (tens_reg <= 4'd9))
        else $error("decimal digit out of range");

endmodule

// ----- bench/tb_ultrasonic_range_to_ascii.sv -----
// Testbench for ultrasonic_range_to_ascii: queued tick/start stimulus, self-checking readout.
`timescale 1ns / 1ps

module tb_ultrasonic_range_to_ascii;

    localparam int DIVISOR_TENTHS = 588;
    localparam int COUNT_WIDTH    = 16;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic start;
        logic echo_lvl;
    } tick_item_t;

    typedef struct packed {
        logic             trigger;
        logic [7:0]       char_code;
        ura_pkg::status_t status;
        logic             last;
    } readout_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    ura_pkg::reg_index_t cfg_index = ura_pkg::REG_TRIGGER_TICKS;
    logic [15:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                cmd = 1'b0;
    logic                echo = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                trigger;
    logic [7:0]          char_code;
    logic [1:0]          status;
    logic                last;

    // ranger model state and its copy of the registers
    ura_pkg::phase_t  ranger_phase = ura_pkg::PH_IDLE;
    logic [15:0]      echo_ticks_seen = '0;
    logic [15:0]      pulse_left = '0;
    logic [15:0]      trig_len = ura_pkg::TRIGGER_TICKS_RESET;
    logic [9:0]       lo_cm = ura_pkg::MIN_CM_RESET;
    logic [9:0]       hi_cm = ura_pkg::MAX_CM_RESET;

    tick_item_t       tick_queue[$];
    readout_t         readout_due[$];
    int unsigned      items_queued = 0;
    int unsigned      items_taken = 0;
    int unsigned      results_seen = 0;
    int unsigned      errors = 0;
    int unsigned      quiet_cycles = 0;
    bit               bursts_on = 1'b1;

    ultrasonic_range_to_ascii #(
        .DIVISOR_TENTHS (DIVISOR_TENTHS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .echo      (echo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .trigger   (trigger),
        .char_code (char_code),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void push_readout(input logic trig, input logic [7:0] ch,
                                         input ura_pkg::status_t st, input logic fin);
        readout_t r;
        r.trigger   = trig;
        r.char_code = ch;
        r.status    = st;
        r.last      = fin;
        readout_due.push_back(r);
    endfunction

    function automatic void predict_readout(input logic start, input logic echo_lvl);
        int unsigned dist_cm;
        logic [7:0]  hund;
        logic [7:0]  tens;
        logic [7:0]  ones;
        if (start)
        begin
            echo_ticks_seen = '0;
            pulse_left      = (trig_len == 16'd0) ? 16'd1 : trig_len;
            ranger_phase    = ura_pkg::PH_TRIGGER;
            push_readout(1'b1, 8'd0, ura_pkg::ST_NONE, 1'b1);
            return;
        end
        case (ranger_phase)
            ura_pkg::PH_TRIGGER:
            begin
                if (pulse_left != 16'd0)
                    pulse_left = pulse_left - 16'd1;
                if (pulse_left == 16'd0)
                begin
                    ranger_phase = ura_pkg::PH_WAIT;
                    push_readout(1'b0, 8'd0, ura_pkg::ST_NONE, 1'b1);
                end
                else
                    push_readout(1'b1, 8'd0, ura_pkg::ST_NONE, 1'b1);
            end
            ura_pkg::PH_WAIT:
            begin
                if (echo_lvl)
                begin
                    echo_ticks_seen = 16'd1;
                    ranger_phase    = ura_pkg::PH_COUNT;
                end
                push_readout(1'b0, 8'd0, ura_pkg::ST_NONE, 1'b1);
            end
            ura_pkg::PH_COUNT:
            begin
                if (echo_lvl)
                begin
                    echo_ticks_seen = echo_ticks_seen + 16'd1;  // wraps at 16 bits
                    push_readout(1'b0, 8'd0, ura_pkg::ST_NONE, 1'b1);
                end
                else
                begin
                    ranger_phase = ura_pkg::PH_IDLE;
                    dist_cm = (echo_ticks_seen * 32'd10) / DIVISOR_TENTHS + 1;
                    if (dist_cm < lo_cm || dist_cm > hi_cm)
                        push_readout(1'b0, 8'd0, ura_pkg::ST_RANGE, 1'b1);
                    else
                    begin
                        hund = 8'(dist_cm / 100);
                        tens = 8'((dist_cm % 100) / 10);
                        ones = 8'(dist_cm % 10);
                        push_readout(1'b0, ura_pkg::ASCII_ZERO + hund, ura_pkg::ST_CHAR, 1'b0);
                        push_readout(1'b0, ura_pkg::ASCII_ZERO + tens, ura_pkg::ST_CHAR, 1'b0);
                        push_readout(1'b0, ura_pkg::ASCII_ZERO + ones, ura_pkg::ST_CHAR, 1'b0);
                        push_readout(1'b0, ura_pkg::ASCII_C, ura_pkg::ST_CHAR, 1'b0);
                        push_readout(1'b0, ura_pkg::ASCII_M, ura_pkg::ST_CHAR, 1'b1);
                    end
                end
            end
            default:
                push_readout(1'b0, 8'd0, ura_pkg::ST_NONE, 1'b1);
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    // sender: offers queued items, random gaps while bursts_on
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        tick_item_t nxt;
        int unsigned send_gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_readout(cmd, echo);
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (bursts_on && tick_queue.size() != 0 && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 5);
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    nxt = tick_queue.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= nxt.start;
                    echo     <= nxt.echo_lvl;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each result transfer, stalls in bursts, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : take_results
        readout_t want;
        int unsigned stall_left;
        int unsigned hold_left;
        bit held_once;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            held_once  = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (readout_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected: trigger %0b char %0h",
                             $time, trigger, char_code);
                    $display("    status %0d last %0b", status, last);
                    errors++;
                end
                else
                begin
                    want = readout_due.pop_front();
                    check_field("trigger", 8'(want.trigger), 8'(trigger));
                    check_field("char_code", want.char_code, char_code);
                    check_field("status", 8'(want.status), 8'(status));
                    check_field("last", 8'(want.last), 8'(last));
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held_once && results_seen >= 90)
            begin
                // long back-pressure so the block stops taking ticks
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_item(input logic start, input logic echo_lvl);
        tick_item_t it;
        it.start    = start;
        it.echo_lvl = echo_lvl;
        tick_queue.push_back(it);
        items_queued++;
    endtask

    // start, trigger pulse (echo random, ignored), wait, echo high, optional falling tick
    task automatic queue_ranging(input int unsigned wait_ticks, input int unsigned high_ticks,
                                 input bit finish_it);
        int unsigned pulse;
        pulse = (trig_len == 16'd0) ? 1 : trig_len;
        queue_item(1'b1, 1'($urandom_range(0, 1)));
        repeat (pulse) queue_item(1'b0, 1'($urandom_range(0, 1)));
        repeat (wait_ticks) queue_item(1'b0, 1'b0);
        repeat (high_ticks) queue_item(1'b0, 1'b1);
        if (finish_it)
            queue_item(1'b0, 1'b0);
    endtask

    task automatic settle();
        while (items_taken != items_queued || readout_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ura_pkg::reg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            ura_pkg::REG_TRIGGER_TICKS: trig_len = val;
            ura_pkg::REG_MIN_CM:        lo_cm = val[9:0];
            ura_pkg::REG_MAX_CM:        hi_cm = val[9:0];
            default:                    ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] pulse_len, input logic [9:0] lo,
                             input logic [9:0] hi);
        settle();
        write_reg(ura_pkg::REG_TRIGGER_TICKS, pulse_len);
        write_reg(ura_pkg::REG_MIN_CM, {6'd0, lo});
        write_reg(ura_pkg::REG_MAX_CM, {6'd0, hi});
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: idle ticks, then the start of a long reset-length pulse
        queue_item(1'b0, 1'b0);
        queue_item(1'b0, 1'b1);
        queue_item(1'b1, 1'b0);
        repeat (3) queue_item(1'b0, 1'($urandom_range(0, 1)));

        // short pulse, reset range window: below the lower edge, then on it
        settle();
        write_reg(ura_pkg::REG_TRIGGER_TICKS, 16'd2);
        queue_ranging(1, 5, 1'b1);
        queue_ranging(0, 59, 1'b1);

        configure(16'd3, 10'd0, 10'd1023);
        queue_item(1'b1, 1'b0);          // start while triggering
        queue_item(1'b0, 1'b1);
        queue_ranging(2, 0, 1'b0);       // left waiting for echo
        queue_ranging(0, 4, 1'b0);       // abandoned mid-count
        queue_ranging(0, 1, 1'b1);       // single echo tick

        configure(16'd0, 10'd5, 10'd3);  // zero pulse, empty window
        queue_ranging(1, 2, 1'b1);

        configure(16'd1, 10'd1, 10'd1);
        queue_ranging(0, 10, 1'b1);

        for (int p = 0; p < 2; p++)
        begin
            configure(($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 3)),
                      10'($urandom_range(0, 2)), 10'($urandom_range(0, 3)));
            // final phase runs without any idling
            bursts_on = (p != 1) && ($urandom_range(0, 3) != 0);
            for (int m = 0; m < 2; m++)
            begin
                repeat ($urandom_range(0, 3))
                    queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                case ($urandom_range(0, 3))
                    0:       queue_ranging($urandom_range(0, 2), $urandom_range(0, 6), 1'b0);
                    default: queue_ranging($urandom_range(0, 2), $urandom_range(1, 8), 1'b1);
                endcase
            end
        end

        settle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
